// ===== src/lmts_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD mode timing sequencer package
// Shared types, mode codes, register indexes and timing constants.
// ----------------------------------------------------------------------------
package lmts_pkg;

  localparam int TICK_W  = 17;
  localparam int LINE_W  = 8;
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 3;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 24;

  // Display modes as seen in the status register.
  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_XFER   = 2'd3;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_DISPLAY_EN = 3'd0;
  localparam logic [IDX_W-1:0] REG_HBLANK_IE  = 3'd1;
  localparam logic [IDX_W-1:0] REG_VBLANK_IE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_OAM_IE     = 3'd3;
  localparam logic [IDX_W-1:0] REG_MATCH_IE   = 3'd4;

  // Timing constants in clock ticks and scan lines.
  localparam logic [TICK_W-1:0] FRAME_TICKS  = 17'd70224;
  localparam logic [TICK_W-1:0] OAM_TICKS    = 17'd80;
  localparam logic [TICK_W-1:0] XFER_TICKS   = 17'd172;
  localparam logic [TICK_W-1:0] HBLANK_TICKS = 17'd204;
  localparam logic [TICK_W-1:0] LINE_TICKS   = 17'd456;
  localparam logic [LINE_W-1:0] VBLANK_LINE  = 8'd144;
  localparam logic [LINE_W-1:0] LAST_LINE    = 8'd153;

  typedef struct packed {
    logic display_en;
    logic hblank_ie;
    logic vblank_ie;
    logic oam_ie;
    logic match_ie;
  } lmts_cfg_t;

  typedef struct packed {
    logic [7:0] line_compare;
    logic [7:0] ticks;
  } lmts_in_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_count;
    logic [MODE_W-1:0] mode;
    logic [MODE_W-1:0] status_mode;
    logic [LINE_W-1:0] line;
    logic              match;
  } lmts_state_t;

  typedef struct packed {
    logic vblank_irq;
    logic status_irq;
    logic line_done;
    logic frame_done;
  } lmts_flags_t;

endpackage

// ===== src/lmts_cfg.sv =====
// ----------------------------------------------------------------------------
// LCD mode timing sequencer configuration registers
// Holds the display enable and the four status interrupt enables.
// ----------------------------------------------------------------------------
module lmts_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lmts_pkg::IDX_W-1:0] cfg_index,
  input  logic                      cfg_data,
  output lmts_pkg::lmts_cfg_t       cfg
);
  import lmts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.display_en <= 1'b1;
      cfg.hblank_ie  <= 1'b0;
      cfg.vblank_ie  <= 1'b0;
      cfg.oam_ie     <= 1'b0;
      cfg.match_ie   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISPLAY_EN: cfg.display_en <= cfg_data;
        REG_HBLANK_IE:  cfg.hblank_ie  <= cfg_data;
        REG_VBLANK_IE:  cfg.vblank_ie  <= cfg_data;
        REG_OAM_IE:     cfg.oam_ie     <= cfg_data;
        REG_MATCH_IE:   cfg.match_ie   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/lmts_step.sv =====
// ----------------------------------------------------------------------------
// LCD mode timing sequencer step logic
// Computes the next timing state and the event flags for one item.
// ----------------------------------------------------------------------------
module lmts_step (
  input  lmts_pkg::lmts_cfg_t   cfg,
  input  lmts_pkg::lmts_in_t    item,
  input  lmts_pkg::lmts_state_t cur,
  output lmts_pkg::lmts_state_t nxt,
  output lmts_pkg::lmts_flags_t flags
);
  import lmts_pkg::*;

  logic [TICK_W:0]   sum;
  logic [TICK_W-1:0] count;
  logic [LINE_W-1:0] line_inc;
  logic              hit;

  assign sum      = {1'b0, cur.tick_count} + {{(TICK_W - 7){1'b0}}, item.ticks};
  assign count    = sum[TICK_W] ? {TICK_W{1'b1}} : sum[TICK_W-1:0];
  assign line_inc = cur.line + 8'd1;
  assign hit      = (line_inc == item.line_compare);

  always_comb begin
    nxt              = cur;
    nxt.tick_count   = count;
    flags            = '0;
    if (!cfg.display_en) begin
      nxt.mode = MODE_HBLANK;
      if (count >= FRAME_TICKS) begin
        nxt.tick_count = count - FRAME_TICKS;
      end
    end else begin
      case (cur.mode)
        MODE_HBLANK: begin
          if (count >= HBLANK_TICKS) begin
            nxt.tick_count = count - HBLANK_TICKS;
            nxt.line       = line_inc;
            nxt.match      = hit;
            if (line_inc == VBLANK_LINE) begin
              nxt.mode         = MODE_VBLANK;
              flags.frame_done = 1'b1;
              flags.vblank_irq = 1'b1;
              flags.status_irq = (hit & cfg.match_ie) | cfg.vblank_ie;
            end else begin
              nxt.mode         = MODE_OAM;
              flags.status_irq = (hit & cfg.match_ie) | cfg.oam_ie;
            end
            nxt.status_mode = nxt.mode;
          end
        end
        MODE_VBLANK: begin
          if (count >= LINE_TICKS) begin
            nxt.tick_count   = count - LINE_TICKS;
            nxt.line         = line_inc;
            nxt.match        = hit;
            flags.status_irq = hit & cfg.match_ie;
            if (line_inc == LAST_LINE) begin
              // The last line is compared, then the frame wraps to line zero.
              nxt.line         = '0;
              nxt.mode         = MODE_OAM;
              nxt.status_mode  = MODE_OAM;
              flags.status_irq = (hit & cfg.match_ie) | cfg.oam_ie;
            end
          end
        end
        MODE_OAM: begin
          if (count >= OAM_TICKS) begin
            nxt.tick_count  = count - OAM_TICKS;
            nxt.mode        = MODE_XFER;
            nxt.status_mode = MODE_XFER;
          end
        end
        default: begin
          if (count >= XFER_TICKS) begin
            nxt.tick_count   = count - XFER_TICKS;
            nxt.mode         = MODE_HBLANK;
            nxt.status_mode  = MODE_HBLANK;
            flags.line_done  = 1'b1;
            flags.status_irq = cfg.hblank_ie;
          end
        end
      endcase
    end
  end

endmodule

// ===== src/lcd_mode_timing_sequencer.sv =====
// ----------------------------------------------------------------------------
// LCD mode timing sequencer
// Walks the LCD display modes from elapsed tick counts and raises interrupts.
// ----------------------------------------------------------------------------
// Each input transfer carries the clock ticks elapsed since the previous one
// and the current line compare value. The block adds the ticks to its mode
// counter and makes at most one mode change per transfer: OAM search takes 80
// ticks, pixel transfer 172, horizontal blank 204, and each vertical blank
// line 456. Line 144 enters vertical blank and line 153 wraps to line 0. One
// result transfer comes out for every input transfer, in order. An item is
// registered in the input register, is stepped through a single adder and
// compare path against the timing state, and lands in the output register;
// a new item is taken every cycle while the output side keeps up. The output
// register holds a result under backpressure and the input register holds one
// more item, after which s_tready drops. Configuration registers are written
// through cfg_we, cfg_index and cfg_data and should be changed only while no
// transfer is in flight.
module lcd_mode_timing_sequencer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [7:0] ticks, [15:8] line_compare
  input  logic [lmts_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [1:0] mode_now, [3:2] status_mode, [11:4] line_now, [12] match_flag,
  // [13] vblank_irq, [14] status_irq, [15] line_done, [16] frame_done,
  // [23:17] zero
  output logic [lmts_pkg::OUT_W-1:0] m_tdata,
  input  logic                       cfg_we,
  input  logic [lmts_pkg::IDX_W-1:0] cfg_index,
  input  logic                       cfg_data
);
  import lmts_pkg::*;

  lmts_cfg_t   cfg;
  lmts_in_t    in_item;
  logic        in_valid;
  lmts_state_t state;
  lmts_state_t state_next;
  lmts_flags_t flags;
  lmts_state_t res_state;
  lmts_flags_t res_flags;
  logic        out_valid;
  logic        step;

  lmts_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lmts_step u_step (
    .cfg   (cfg),
    .item  (in_item),
    .cur   (state),
    .nxt   (state_next),
    .flags (flags)
  );

  // The held item steps whenever the output register is empty or draining.
  assign step     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= s_tdata;
    end
  end

  // Timing state advances once per stepped item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_state <= state_next;
      res_flags <= flags;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, res_flags.frame_done, res_flags.line_done,
                     res_flags.status_irq, res_flags.vblank_irq, res_state.match,
                     res_state.line, res_state.status_mode, res_state.mode};

  // Vertical blank is only ever entered at line 144, so no earlier line shows in it.
  a_vblank_lines: assert property (@(posedge clk) disable iff (rst)
    state.mode == MODE_VBLANK |-> state.line >= VBLANK_LINE)
    else $error("vertical blank mode outside the vertical blank lines");

  // A frame-done result reports the first vertical blank line.
  a_frame_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_flags.frame_done) |->
      (res_state.mode == MODE_VBLANK && res_state.line == VBLANK_LINE))
    else $error("frame done without entering vertical blank");

  // A line-done result always lands in horizontal blank.
  a_line_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_flags.line_done) |->
      (res_state.mode == MODE_HBLANK && res_state.status_mode == MODE_HBLANK))
    else $error("line done without entering horizontal blank");

  // A stepped item always produces a result in the next cycle.
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("stepped item produced no result");

endmodule
